// ----- src/tftp_wr_pkg.sv -----
package tftp_wr_pkg;

  // Payload length of a full DATA packet
  localparam int BLOCK_SIZE = 512;

  // Byte position counts header and payload, saturating at BLOCK_SIZE + 4
  localparam int POS_W = $clog2(BLOCK_SIZE + 5);
  localparam logic [POS_W-1:0] BLK_SZ = POS_W'(BLOCK_SIZE);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(BLOCK_SIZE + 4);

  // Result queue geometry
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int MAX_RES = 3;

  // Opcodes and characters
  localparam logic [15:0] OP_DATA = 16'd3;
  localparam logic [15:0] OP_ERROR = 16'd5;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Error codes
  localparam logic [2:0] ERR_UNDEF = 3'd0;
  localparam logic [2:0] ERR_ILLEGAL = 3'd4;

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_TIMEOUT = 2'd1,
    ACT_START   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_FILE  = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_AWAIT  = 3'b010,
    PH_PACKET = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  file_byte;
    logic [15:0] block_number;
    logic [2:0]  error_code;
    logic        transfer_done;
    logic        last_result;
  } result_t;

  // Group of results produced by one accepted item
  typedef struct packed {
    logic [1:0]          cnt;
    result_t [MAX_RES-1:0] ent;
  } push_t;

endpackage

// ----- src/tftp_wr_core.sv -----
module tftp_wr_core
  import tftp_wr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  input  logic       netascii_mode_i,
  output push_t      push_o
);

  phase_e            phase_q, phase_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [15:0]       op_q, op_d;
  logic [15:0]       rblk_q, rblk_d;
  logic [15:0]       exp_q, exp_d;
  logic [15:0]       lack_q, lack_d;
  logic              nasc_q, nasc_d;
  logic              cr_q, cr_d;

  // Per-item scratch values
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pidx;
  logic [15:0]       op_cur;
  logic [15:0]       rblk_new;
  logic              cr_cur;
  logic              final_b;
  logic [7:0]        pb0, pb1;
  logic [1:0]        pn;
  logic              tv;
  result_t           trl;
  push_t             push;

  // Next-state and result generation for one item
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    op_d     = op_q;
    rblk_d   = rblk_q;
    exp_d    = exp_q;
    lack_d   = lack_q;
    nasc_d   = nasc_q;
    cr_d     = cr_q;
    pos      = pos_q;
    pidx     = pos_q - POS_W'(4);
    op_cur   = op_q;
    rblk_new = {rblk_q[7:0], data_byte_i};
    cr_cur   = cr_q;
    final_b  = 1'b0;
    pb0      = '0;
    pb1      = '0;
    pn       = 2'd0;
    tv       = 1'b0;
    trl      = '0;

    case (action_i)
      ACT_START: begin
        nasc_d  = netascii_mode_i;
        exp_d   = 16'd1;
        lack_d  = 16'd0;
        pos_d   = '0;
        op_d    = '0;
        rblk_d  = '0;
        cr_d    = 1'b0;
        phase_d = PH_AWAIT;
        tv      = 1'b1;
        trl.kind = KIND_ACK;
      end
      ACT_TIMEOUT: begin
        if (phase_q != PH_IDLE) begin
          phase_d  = PH_AWAIT;
          cr_d     = 1'b0;
          pos_d    = '0;
          tv       = 1'b1;
          trl.kind = KIND_ACK;
          trl.block_number = lack_q;
        end
      end
      ACT_BYTE: begin
        if (phase_q != PH_IDLE && (first_byte_i || phase_q == PH_PACKET)) begin
          if (first_byte_i) begin
            pos    = '0;
            op_cur = '0;
            cr_cur = 1'b0;
            rblk_new = {8'h00, data_byte_i};
            op_d   = '0;
            rblk_d = '0;
            cr_d   = 1'b0;
          end
          phase_d = PH_PACKET;
          pidx    = pos - POS_W'(4);
          if (pos < POS_W'(4)) begin
            // Header bytes: opcode then block number, big-endian
            if (pos < POS_W'(2)) op_d = {op_cur[7:0], data_byte_i};
            else rblk_d = rblk_new;
            pos_d = pos + POS_W'(1);
            if (pos == POS_W'(3)) begin
              if (op_cur == OP_ERROR) begin
                phase_d = PH_IDLE;
              end else if (op_cur != OP_DATA) begin
                tv = 1'b1;
                trl.kind = KIND_ERROR;
                trl.error_code = ERR_ILLEGAL;
                trl.transfer_done = 1'b1;
                phase_d = PH_IDLE;
                cr_d = 1'b0;
              end else if (rblk_new != exp_q) begin
                tv = 1'b1;
                trl.kind = KIND_ERROR;
                trl.error_code = ERR_UNDEF;
                trl.transfer_done = 1'b1;
                phase_d = PH_IDLE;
                cr_d = 1'b0;
              end else if (last_byte_i) begin
                // Empty payload: final ACK
                tv = 1'b1;
                trl.kind = KIND_ACK;
                trl.block_number = exp_q;
                trl.transfer_done = 1'b1;
                lack_d = exp_q;
                cr_d = 1'b0;
                phase_d = PH_IDLE;
              end
            end else if (last_byte_i) begin
              // Packet ended inside the header
              tv = 1'b1;
              trl.kind = KIND_ERROR;
              trl.error_code = ERR_ILLEGAL;
              trl.transfer_done = 1'b1;
              phase_d = PH_IDLE;
              cr_d = 1'b0;
            end
          end else begin
            // Payload byte, dropped past the block size
            if (pidx < BLK_SZ) begin
              final_b = last_byte_i || (pidx == BLK_SZ - POS_W'(1));
              if (!nasc_q) begin
                pb0 = data_byte_i;
                pn  = 2'd1;
              end else if (cr_cur && data_byte_i == CH_LF) begin
                cr_d = 1'b0;
                pb0  = CH_LF;
                pn   = 2'd1;
              end else if (cr_cur && data_byte_i == CH_NUL) begin
                cr_d = 1'b0;
                pb0  = CH_CR;
                pn   = 2'd1;
              end else begin
                // Held CR flushes ahead of this byte
                cr_d = 1'b0;
                if (data_byte_i == CH_CR) begin
                  if (final_b) begin
                    if (cr_cur) begin
                      pb0 = CH_CR;
                      pb1 = CH_CR;
                      pn  = 2'd2;
                    end else begin
                      pb0 = CH_CR;
                      pn  = 2'd1;
                    end
                  end else begin
                    cr_d = 1'b1;
                    if (cr_cur) begin
                      pb0 = CH_CR;
                      pn  = 2'd1;
                    end
                  end
                end else if (cr_cur) begin
                  pb0 = CH_CR;
                  pb1 = data_byte_i;
                  pn  = 2'd2;
                end else begin
                  pb0 = data_byte_i;
                  pn  = 2'd1;
                end
              end
            end
            if (pos < POS_MAX) pos_d = pos + POS_W'(1);
            if (last_byte_i) begin
              tv = 1'b1;
              trl.kind = KIND_ACK;
              trl.block_number = exp_q;
              lack_d = exp_q;
              cr_d = 1'b0;
              if (pidx >= BLK_SZ - POS_W'(1)) begin
                exp_d   = exp_q + 16'd1;
                phase_d = PH_AWAIT;
              end else begin
                trl.transfer_done = 1'b1;
                phase_d = PH_IDLE;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Pack file bytes ahead of the trailing ACK or ERROR
  always_comb begin
    push     = '0;
    push.cnt = pn + {1'b0, tv};
    case (pn)
      2'd2: begin
        push.ent[0].file_byte = pb0;
        push.ent[1].file_byte = pb1;
        push.ent[2] = trl;
      end
      2'd1: begin
        push.ent[0].file_byte = pb0;
        push.ent[1] = trl;
      end
      default: begin
        push.ent[0] = trl;
      end
    endcase
    case (push.cnt)
      2'd1: push.ent[0].last_result = 1'b1;
      2'd2: push.ent[1].last_result = 1'b1;
      2'd3: push.ent[2].last_result = 1'b1;
      default: begin
      end
    endcase
    if (!accept_i) push.cnt = 2'd0;
  end

  assign push_o = push;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      op_q    <= '0;
      rblk_q  <= '0;
      exp_q   <= 16'd1;
      lack_q  <= '0;
      nasc_q  <= 1'b0;
      cr_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      op_q    <= op_d;
      rblk_q  <= rblk_d;
      exp_q   <= exp_d;
      lack_q  <= lack_d;
      nasc_q  <= nasc_d;
      cr_q    <= cr_d;
    end
  end

endmodule

// ----- src/tftp_wr_queue.sv -----
module tftp_wr_queue
  import tftp_wr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t head_o
);

  result_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              pop;

  // Room for a full group of results is required before a transfer
  assign full_o      = cnt_q > QCNT_W'(QDEPTH - MAX_RES);
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = mem_q[rd_q];

  // Group write into consecutive slots
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_i.cnt) mem_q[wr_q + QPTR_W'(i)] <= push_i.ent[i];
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPTR_W'(push_i.cnt);
      if (pop) rd_q <= rd_q + QPTR_W'(1);
      cnt_q <= cnt_q + QCNT_W'(push_i.cnt) - QCNT_W'(pop);
    end
  end

endmodule

// ----- src/tftp_write_receiver_top.sv -----
// TFTP write-transfer receiver, netascii capable.
// Input channel (in_valid_i / in_stall_o) carries one item per transfer:
// a start command, a receive timeout or one packet byte with first/last marks.
// Output channel (out_valid_o / out_stall_i) carries result items: file bytes,
// ACK requests and ERROR requests, with last_result_o on the final result of
// each input item and transfer_done_o on the result that ends the transfer.
// With the result queue empty, the first result of an item is visible in the
// cycle after its transfer; otherwise it waits behind older results.
// Throughput: one input item per cycle while items yield at most one result
// each and the output is taken every cycle; an item may yield up to three
// results, drained one per cycle while out_stall_i is low from an eight-entry result queue.
// in_stall_o rises when fewer than three queue slots are free, so a stalled
// receiver holds back the input after the queue fills; no result is ever
// dropped.
// Reset: asynchronous, active low; the block goes idle with the queue empty,
// expected block 1 and last acknowledged block 0.
module tftp_write_receiver_top
  import tftp_wr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic        netascii_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  file_byte_o,
  output logic [15:0] block_number_o,
  output logic [2:0]  error_code_o,
  output logic        transfer_done_o,
  output logic        last_result_o
);

  logic    full;
  logic    accept;
  push_t   push;
  result_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  tftp_wr_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .action_i        (action_i),
    .data_byte_i     (data_byte_i),
    .first_byte_i    (first_byte_i),
    .last_byte_i     (last_byte_i),
    .netascii_mode_i (netascii_mode_i),
    .push_o          (push)
  );

  tftp_wr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign result_kind_o   = head.kind;
  assign file_byte_o     = head.file_byte;
  assign block_number_o  = head.block_number;
  assign error_code_o    = head.error_code;
  assign transfer_done_o = head.transfer_done;
  assign last_result_o   = head.last_result;

endmodule
